>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the call-rate block.
// Needs a clk and an active-low rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the cycle after ante, outside reset
`define CRMA_CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Check cons in the same cycle as ante, outside reset
`define CRMA_CHK_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check cons in the cycle after ante, reset included
`define CRMA_CHK_RAW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/core/crma_pkg.sv
// Shared types and constants of the call-rate moving-average block.
// No dependencies.
package crma_pkg;

  localparam int NUM_CLIENTS_DEF = 16;
  localparam int NUM_FUNCS_DEF   = 256;

  localparam int IN_DATA_W  = 144;
  localparam int OUT_DATA_W = 120;
  localparam int DISC_W     = 17;
  localparam int AVG_W      = 56;
  localparam int UNIT_W     = 32;
  localparam int SAMP_W     = 32;
  localparam int WORD_W     = 64;

  // Divider dividend: 116-bit product shifted left by 16
  localparam int DVD_W      = 132;
  localparam int MUL_A_W    = 96;
  localparam int MUL_B_W    = 32;
  localparam int MUL_P_W    = 128;
  localparam int ITER_W     = 8;

  localparam logic [DISC_W-1:0] DISC_RESET = 17'd6554;
  localparam logic [DISC_W-1:0] DISC_ONE   = 17'd65536;
  localparam logic [WORD_W-1:0] NS_PER_MS  = 64'd1000000;
  localparam logic [AVG_W-1:0]  AVG_MAX    = {AVG_W{1'b1}};

  typedef enum logic [2:0] {
    ST_UPDATED    = 3'd0,
    ST_INIT       = 3'd1,
    ST_NO_CALLS   = 3'd2,
    ST_FIRST      = 3'd3,
    ST_COUNT_DOWN = 3'd4,
    ST_TIME_STUCK = 3'd5,
    ST_READ       = 3'd6
  } status_t;

  typedef enum logic {
    OP_OBSERVE = 1'b0,
    OP_READ    = 1'b1
  } op_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] quot;
    logic              rem_nz;
    logic              sat;
  } div_res_t;

endpackage

>>> rtl/core/call_rate_moving_average_unit.sv
// Call-rate moving average: per-function average of call rates.
// Read, count-down, no-calls, first-time and stuck items go from lookup to the result;
// an update runs two multiplies and a rate divide, and the first rate one more multiply
// and a unit divide ahead of those. One item at a time: the next is taken once its
// result issues.
// Reset: synchronous; a clearing pass over all NUM_CLIENTS*NUM_FUNCS pair entries zeroes both memories.
module call_rate_moving_average_unit #(
  parameter int NUM_CLIENTS = crma_pkg::NUM_CLIENTS_DEF,
  parameter int NUM_FUNCS   = crma_pkg::NUM_FUNCS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [crma_pkg::DISC_W-1:0]      cfg_data,     // discount
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // client[3:0], func[11:4], timestamp_ns[75:12], call_count[139:76], zero fill
  input  logic [crma_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic                             in_tuser,     // op
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // avg_rate[55:0], unit_ms[87:56], samples_seen[119:88]
  output logic [crma_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic [2:0]                       out_tuser     // status
);

  localparam int PAIR_DEPTH = NUM_CLIENTS * NUM_FUNCS;
  localparam int PW = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;
  localparam int FW = (NUM_FUNCS > 1) ? $clog2(NUM_FUNCS) : 1;
  localparam int CW = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
  localparam int PAIR_W = 2 * crma_pkg::WORD_W;
  localparam int FUNC_W = crma_pkg::AVG_W + crma_pkg::UNIT_W + crma_pkg::SAMP_W;
  localparam int W = crma_pkg::WORD_W;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_LOOK, S_CHK, S_DIV1, S_DIV2, S_MUL1, S_MUL2,
    S_DIVR, S_SC1, S_SC2, S_WB, S_OUT
  } state_t;

  state_t state_r;

  // Index wrap tables
  logic [CW-1:0] cmod_tab [16];
  logic [FW-1:0] fmod_tab [256];
  for (genvar i = 0; i < 16; i++) begin : g_cmod
    assign cmod_tab[i] = CW'(i % NUM_CLIENTS);
  end
  for (genvar i = 0; i < 256; i++) begin : g_fmod
    assign fmod_tab[i] = FW'(i % NUM_FUNCS);
  end

  // Memories
  logic [PAIR_W-1:0] pair_mem [PAIR_DEPTH];
  logic [FUNC_W-1:0] func_mem [NUM_FUNCS];
  logic [PAIR_W-1:0] pair_q_r;
  logic [FUNC_W-1:0] func_q_r;
  logic              pair_we, func_we;
  logic [PW-1:0]     pair_wa;
  logic [FW-1:0]     func_wa;
  logic [PAIR_W-1:0] pair_wd;
  logic [FUNC_W-1:0] func_wd;

  // Item registers
  logic                           op_r;
  logic [PW-1:0]                  pair_addr_r;
  logic [FW-1:0]                  func_addr_r;
  logic [W-1:0]                   now_r, cnt_r, elapsed_r, calls_r;
  logic [crma_pkg::AVG_W-1:0]     avg_r, diff_r;
  logic [crma_pkg::UNIT_W-1:0]    unit_r;
  logic [crma_pkg::SAMP_W-1:0]    samp_r, samp_inc;
  logic                           up_r, first_r;
  logic [2:0]                     status_r;
  logic [56:0]                    hi_r;
  logic [16:0]                    lo_r;
  logic [PW-1:0]                  clr_r;
  logic [crma_pkg::DISC_W-1:0]    disc_r, disc_eff;

  // Output registers
  logic                           out_valid_r;
  logic [crma_pkg::OUT_DATA_W-1:0] out_data_r;
  logic [2:0]                     out_user_r;

  // Arithmetic units
  logic                          div_start_r, mul_start_r;
  logic [crma_pkg::ITER_W-1:0]   div_iters_r;
  logic [crma_pkg::DVD_W-1:0]    div_dvd_r;
  logic [W-1:0]                  div_dsr_r;
  crma_pkg::div_res_t            div_res;
  logic [crma_pkg::MUL_A_W-1:0]  mul_a_r;
  logic [crma_pkg::MUL_B_W-1:0]  mul_b_r;
  logic                          mul_done;
  logic [crma_pkg::MUL_P_W-1:0]  mul_prod;

  crma_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start_r), .iters(div_iters_r),
    .dividend(div_dvd_r), .divisor(div_dsr_r), .res(div_res)
  );

  crma_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start_r), .a(mul_a_r), .b(mul_b_r),
    .done(mul_done), .prod(mul_prod)
  );

  // Stored fields
  logic [W-1:0] prev, then_t, u64;
  logic [crma_pkg::AVG_W-1:0]  q_avg, rate, step_sum;
  logic [crma_pkg::UNIT_W-1:0] q_unit;
  logic [crma_pkg::SAMP_W-1:0] q_samp;
  logic [56:0]                 step;
  logic                        new_calls, time_ok;

  always_comb begin
    prev      = pair_q_r[W-1:0];
    then_t    = pair_q_r[PAIR_W-1:W];
    q_avg     = func_q_r[crma_pkg::AVG_W-1:0];
    q_unit    = func_q_r[crma_pkg::AVG_W +: crma_pkg::UNIT_W];
    q_samp    = func_q_r[FUNC_W-1 -: crma_pkg::SAMP_W];
    new_calls = cnt_r > prev;
    time_ok   = then_t == '0 || now_r > then_t;
    u64       = div_res.quot + W'(div_res.rem_nz);
    rate      = div_res.sat ? crma_pkg::AVG_MAX : div_res.quot[crma_pkg::AVG_W-1:0];
    disc_eff  = (disc_r > crma_pkg::DISC_ONE) ? crma_pkg::DISC_ONE : disc_r;
    step      = hi_r + 57'(lo_r);
    step_sum  = up_r ? crma_pkg::AVG_W'(57'(avg_r) + step)
                     : crma_pkg::AVG_W'(57'(avg_r) - step);
    samp_inc  = (samp_r == '1) ? samp_r : samp_r + 1'b1;
  end

  // Memory write ports: clearing pass, then item write-back
  always_comb begin
    pair_we = (state_r == S_CLR) ||
              (state_r == S_CHK && op_r == crma_pkg::OP_OBSERVE && new_calls && time_ok);
    pair_wa = (state_r == S_CLR) ? clr_r : pair_addr_r;
    pair_wd = (state_r == S_CLR) ? '0 : {now_r, cnt_r};
    func_we = (state_r == S_CLR && {1'b0, clr_r} < (PW + 1)'(NUM_FUNCS)) ||
              (state_r == S_WB);
    func_wa = (state_r == S_CLR) ? clr_r[FW-1:0] : func_addr_r;
    func_wd = (state_r == S_CLR) ? '0 : {samp_inc, unit_r, avg_r};
  end

  always_ff @(posedge clk) begin
    if (pair_we) pair_mem[pair_wa] <= pair_wd;
    if (state_r == S_LOOK) pair_q_r <= pair_mem[pair_addr_r];
  end

  always_ff @(posedge clk) begin
    if (func_we) func_mem[func_wa] <= func_wd;
    if (state_r == S_LOOK) func_q_r <= func_mem[func_addr_r];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      div_start_r <= 1'b0;
      mul_start_r <= 1'b0;
      disc_r      <= crma_pkg::DISC_RESET;
    end else begin
      div_start_r <= 1'b0;
      mul_start_r <= 1'b0;
      if (cfg_valid) disc_r <= cfg_data;
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == PW'(PAIR_DEPTH - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_tvalid) begin
            op_r        <= in_tuser;
            pair_addr_r <= PW'(cmod_tab[in_tdata[3:0]]) * PW'(NUM_FUNCS)
                           + PW'(fmod_tab[in_tdata[11:4]]);
            func_addr_r <= fmod_tab[in_tdata[11:4]];
            now_r       <= in_tdata[75:12];
            cnt_r       <= in_tdata[139:76];
            state_r     <= S_LOOK;
          end
        end
        S_LOOK: state_r <= S_CHK;
        S_CHK: begin
          avg_r     <= q_avg;
          unit_r    <= q_unit;
          samp_r    <= q_samp;
          elapsed_r <= now_r - then_t;
          calls_r   <= cnt_r - prev;
          first_r   <= q_unit == '0;
          state_r   <= S_OUT;
          priority if (op_r == crma_pkg::OP_READ) begin
            status_r <= crma_pkg::ST_READ;
          end else if (cnt_r < prev) begin
            status_r <= crma_pkg::ST_COUNT_DOWN;
          end else if (cnt_r == prev) begin
            status_r <= crma_pkg::ST_NO_CALLS;
          end else if (then_t == '0) begin
            status_r <= crma_pkg::ST_FIRST;
          end else if (now_r <= then_t) begin
            status_r <= crma_pkg::ST_TIME_STUCK;
          end else if (q_unit == '0) begin
            // Time unit: ceil(elapsed / (calls * 1e6)); form the divisor first
            mul_start_r <= 1'b1;
            mul_a_r     <= crma_pkg::MUL_A_W'(cnt_r - prev);
            mul_b_r     <= crma_pkg::MUL_B_W'(crma_pkg::NS_PER_MS);
            state_r     <= S_DIV1;
          end else begin
            mul_start_r <= 1'b1;
            mul_a_r     <= crma_pkg::MUL_A_W'(cnt_r - prev);
            mul_b_r     <= q_unit;
            state_r     <= S_MUL1;
          end
        end
        S_DIV1: begin
          // A divisor past 64 bits exceeds any elapsed time: the unit is one
          if (mul_done) begin
            if (mul_prod[crma_pkg::MUL_P_W-1:W] != '0) begin
              unit_r      <= crma_pkg::UNIT_W'(1);
              mul_start_r <= 1'b1;
              mul_a_r     <= crma_pkg::MUL_A_W'(calls_r);
              mul_b_r     <= crma_pkg::MUL_B_W'(1);
              state_r     <= S_MUL1;
            end else begin
              div_start_r <= 1'b1;
              div_iters_r <= crma_pkg::ITER_W'(W);
              div_dvd_r   <= {elapsed_r, (crma_pkg::DVD_W - W)'(0)};
              div_dsr_r   <= mul_prod[W-1:0];
              state_r     <= S_DIV2;
            end
          end
        end
        S_DIV2: begin
          if (div_res.done) begin
            unit_r      <= (u64[W-1:crma_pkg::UNIT_W] != '0) ? '1
                           : u64[crma_pkg::UNIT_W-1:0];
            mul_start_r <= 1'b1;
            mul_a_r     <= crma_pkg::MUL_A_W'(calls_r);
            mul_b_r     <= (u64[W-1:crma_pkg::UNIT_W] != '0) ? '1
                           : u64[crma_pkg::UNIT_W-1:0];
            state_r     <= S_MUL1;
          end
        end
        S_MUL1: begin
          if (mul_done) begin
            mul_start_r <= 1'b1;
            mul_a_r     <= mul_prod[crma_pkg::MUL_A_W-1:0];
            mul_b_r     <= crma_pkg::MUL_B_W'(crma_pkg::NS_PER_MS);
            state_r     <= S_MUL2;
          end
        end
        S_MUL2: begin
          if (mul_done) begin
            div_start_r <= 1'b1;
            div_iters_r <= crma_pkg::ITER_W'(crma_pkg::DVD_W);
            div_dvd_r   <= {mul_prod[crma_pkg::DVD_W-17:0], 16'd0};
            div_dsr_r   <= elapsed_r;
            state_r     <= S_DIVR;
          end
        end
        S_DIVR: begin
          if (div_res.done) begin
            if (first_r) begin
              avg_r    <= rate;
              status_r <= crma_pkg::ST_INIT;
              state_r  <= S_WB;
            end else begin
              up_r    <= rate >= avg_r;
              diff_r  <= (rate >= avg_r) ? rate - avg_r : avg_r - rate;
              state_r <= S_SC1;
            end
          end
        end
        S_SC1: begin
          // Split the discount product into two narrow multiplies
          hi_r    <= 57'(diff_r[crma_pkg::AVG_W-1:16]) * 57'(disc_eff);
          lo_r    <= 17'((33'(diff_r[15:0]) * 33'(disc_eff)) >> 16);
          state_r <= S_SC2;
        end
        S_SC2: begin
          avg_r    <= step_sum;
          status_r <= crma_pkg::ST_UPDATED;
          state_r  <= S_WB;
        end
        S_WB: begin
          samp_r  <= samp_inc;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {samp_r, unit_r, avg_r};
            out_user_r  <= status_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign cfg_ready  = 1'b1;
  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

>>> rtl/core/crma_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on crma_pkg.
module crma_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [crma_pkg::ITER_W-1:0]   iters,
  input  logic [crma_pkg::DVD_W-1:0]    dividend,
  input  logic [crma_pkg::WORD_W-1:0]   divisor,
  output crma_pkg::div_res_t            res
);

  logic [crma_pkg::WORD_W-1:0] rem_r, rem_nxt, dsr_r, q_r;
  logic [crma_pkg::DVD_W-1:0]  dvd_r;
  logic [crma_pkg::ITER_W-1:0] cnt_r;
  logic                        busy_r, done_r, sat_r;
  logic [crma_pkg::WORD_W:0]   rem_sh;
  logic                        ge;

  // Shift in one dividend bit and trial-subtract
  always_comb begin
    rem_sh  = {rem_r, dvd_r[crma_pkg::DVD_W-1]};
    ge      = rem_sh >= {1'b0, dsr_r};
    rem_nxt = ge ? crma_pkg::WORD_W'(rem_sh - {1'b0, dsr_r})
                 : rem_sh[crma_pkg::WORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        rem_r  <= '0;
        q_r    <= '0;
        sat_r  <= 1'b0;
        dvd_r  <= dividend;
        dsr_r  <= divisor;
        cnt_r  <= iters;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        dvd_r <= {dvd_r[crma_pkg::DVD_W-2:0], 1'b0};
        q_r   <= {q_r[crma_pkg::WORD_W-2:0], ge};
        // Quotient bit at or above bit 56 overflows the rate format
        if (ge && cnt_r > crma_pkg::ITER_W'(crma_pkg::AVG_W)) sat_r <= 1'b1;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == crma_pkg::ITER_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign res.done   = done_r;
  assign res.quot   = q_r;
  assign res.rem_nz = rem_r != '0;
  assign res.sat    = sat_r;

endmodule

>>> rtl/core/crma_mul.sv
// Shift-add multiplier, one multiplier bit per cycle over all 32 multiplier bits.
// Depends on crma_pkg.
module crma_mul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [crma_pkg::MUL_A_W-1:0]  a,
  input  logic [crma_pkg::MUL_B_W-1:0]  b,
  output logic                          done,
  output logic [crma_pkg::MUL_P_W-1:0]  prod
);

  localparam int CW = $clog2(crma_pkg::MUL_B_W + 1);

  logic [crma_pkg::MUL_P_W-1:0] a_r, acc_r;
  logic [crma_pkg::MUL_B_W-1:0] b_r;
  logic [CW-1:0]                cnt_r;
  logic                         busy_r, done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        a_r    <= crma_pkg::MUL_P_W'(a);
        b_r    <= b;
        acc_r  <= '0;
        cnt_r  <= CW'(crma_pkg::MUL_B_W);
      end else if (busy_r) begin
        // Add the shifted multiplicand for each set bit
        if (b_r[0]) acc_r <= acc_r + a_r;
        a_r   <= {a_r[crma_pkg::MUL_P_W-2:0], 1'b0};
        b_r   <= {1'b0, b_r[crma_pkg::MUL_B_W-1:1]};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

>>> rtl/core/crma_checker.sv
// Port-level checks of the call-rate block, bound to the top level.
// Depends on crma_pkg and assert_macros.svh.
`include "assert_macros.svh"

module crma_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [crma_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic [2:0]                       out_tuser
);

  // Reset drops results and starts the clearing pass
  `CRMA_CHK_RAW(a_reset_quiet, !rst_n, !out_tvalid && !in_tready)

  // One item in flight: no accept right after an accept
  `CRMA_CHK_NEXT(a_one_item, in_tvalid && in_tready, !in_tready)

  // A folded rate implies a set unit and a nonzero sample count
  `CRMA_CHK_NOW(a_rate_fields, out_tvalid && (out_tuser == crma_pkg::ST_UPDATED || out_tuser == crma_pkg::ST_INIT), out_tdata[87:56] != '0 && out_tdata[119:88] != '0)

  // Hold a stalled result
  `CRMA_CHK_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

endmodule

bind call_rate_moving_average_unit crma_checker u_crma_checker (.*);

>>> tb/sv/call_rate_moving_average_unit_tb.sv
// Self-checking testbench of call_rate_moving_average_unit.
// Needs crma_pkg and the block's RTL; a scoreboard class predicts every result.
module call_rate_moving_average_unit_tb;
  import crma_pkg::*;

  typedef struct {
    status_t           status;
    logic [AVG_W-1:0]  avg_rate;
    logic [UNIT_W-1:0] unit_ms;
    logic [SAMP_W-1:0] samples_seen;
  } rate_result_t;

  // Holds its own copy of per-pair and per-function state, predicts each result
  class rate_scoreboard;
    bit [63:0]       last_cnt[NUM_CLIENTS_DEF*NUM_FUNCS_DEF];
    bit [63:0]       last_ts[NUM_CLIENTS_DEF*NUM_FUNCS_DEF];
    bit [AVG_W-1:0]  fn_avg[NUM_FUNCS_DEF];
    bit [UNIT_W-1:0] fn_unit[NUM_FUNCS_DEF];
    bit [SAMP_W-1:0] fn_samples[NUM_FUNCS_DEF];
    bit [DISC_W-1:0] discount;
    rate_result_t    expected_q[$];
    int              errors;

    function new();
      foreach (last_cnt[i]) begin
        last_cnt[i] = 0;
        last_ts[i]  = 0;
      end
      foreach (fn_avg[i]) begin
        fn_avg[i]     = 0;
        fn_unit[i]    = 0;
        fn_samples[i] = 0;
      end
      discount = DISC_RESET;
      errors   = 0;
    endfunction

    // floor(calls * unit * 1e6 * 2^16 / elapsed), saturated to 56 bits
    function bit [AVG_W-1:0] calls_per_unit(bit [63:0] calls, bit [31:0] unit,
                                            bit [63:0] elapsed);
      bit [191:0] num;
      bit [191:0] quo;
      num = calls;
      num = num * unit;
      num = num * 64'd1000000;
      num = num << 16;
      quo = num / elapsed;
      if ((quo >> AVG_W) != 0) return AVG_MAX;
      return quo[AVG_W-1:0];
    endfunction

    function bit [63:0] weighted_step(bit [63:0] x, bit [16:0] d);
      bit [63:0] dd;
      dd = d;
      return (x >> 16) * dd + (((x & 64'hFFFF) * dd) >> 16);
    endfunction

    function void note_input(op_t op, bit [3:0] client, bit [7:0] func,
                             bit [63:0] now, bit [63:0] cnt);
      rate_result_t r;
      int           k;
      bit [63:0]    elapsed, calls, per, u, a, rate;
      bit [16:0]    d;
      k = client * NUM_FUNCS_DEF + func;
      if (op == OP_READ) begin
        r.status = ST_READ;
      end else if (cnt < last_cnt[k]) begin
        r.status = ST_COUNT_DOWN;
      end else if (cnt == last_cnt[k]) begin
        r.status = ST_NO_CALLS;
      end else if (last_ts[k] == 0) begin
        last_cnt[k] = cnt;
        last_ts[k]  = now;
        r.status    = ST_FIRST;
      end else if (now <= last_ts[k]) begin
        r.status = ST_TIME_STUCK;
      end else begin
        elapsed     = now - last_ts[k];
        calls       = cnt - last_cnt[k];
        last_cnt[k] = cnt;
        last_ts[k]  = now;
        if (fn_unit[func] == 0) begin
          // fix the unit as ceil(ceil(elapsed / calls) / 1e6), saturating
          per = elapsed / calls + ((elapsed % calls) != 0);
          u   = per / 64'd1000000 + ((per % 64'd1000000) != 0);
          if (u > 64'hFFFF_FFFF) u = 64'hFFFF_FFFF;
          fn_unit[func] = u[31:0];
          fn_avg[func]  = calls_per_unit(calls, fn_unit[func], elapsed);
          r.status      = ST_INIT;
        end else begin
          d    = (discount > DISC_ONE) ? DISC_ONE : discount;
          a    = fn_avg[func];
          rate = calls_per_unit(calls, fn_unit[func], elapsed);
          if (rate >= a) a = a + weighted_step(rate - a, d);
          else a = a - weighted_step(a - rate, d);
          fn_avg[func] = a[AVG_W-1:0];
          r.status     = ST_UPDATED;
        end
        if (fn_samples[func] != 32'hFFFF_FFFF) fn_samples[func]++;
      end
      r.avg_rate     = fn_avg[func];
      r.unit_ms      = fn_unit[func];
      r.samples_seen = fn_samples[func];
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [2:0] status, logic [OUT_DATA_W-1:0] data);
      rate_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result status %0d data %h", $time, status, data);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (status !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, status);
        errors++;
      end
      if (data[55:0] !== e.avg_rate) begin
        $display("%0t: avg_rate expected %h actual %h", $time, e.avg_rate, data[55:0]);
        errors++;
      end
      if (data[87:56] !== e.unit_ms) begin
        $display("%0t: unit_ms expected %0d actual %0d", $time, e.unit_ms, data[87:56]);
        errors++;
      end
      if (data[119:88] !== e.samples_seen) begin
        $display("%0t: samples_seen expected %0d actual %0d", $time, e.samples_seen,
                 data[119:88]);
        errors++;
      end
    endfunction
  endclass

  localparam int STALL_LIMIT = 20000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [DISC_W-1:0]     cfg_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [2:0]            out_tuser;

  rate_scoreboard sb = new();
  int             tx_idle_pct = 0;
  int             rx_idle_pct = 0;
  int             stall_cycles = 0;

  always #1 clk = ~clk;

  call_rate_moving_average_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  // Check each result transaction, then stall the result side at random
  always @(posedge clk) begin
    if (out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata);
    out_tready <= rst_n && ($urandom_range(99) >= rx_idle_pct);
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready) || !rst_n)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_item(op_t op, bit [3:0] client, bit [7:0] func,
                           bit [63:0] now, bit [63:0] cnt);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'b0, cnt, now, func, client};
    do @(posedge clk); while (!in_tready);
    sb.note_input(op, client, func, now, cnt);
  endtask

  // Write the discount once the block has drained
  task automatic write_discount(bit [DISC_W-1:0] value);
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.discount = value;
  endtask

  function automatic bit [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly well-formed sample sequences on a few hot functions, plus noise
  task automatic random_items(int count);
    bit [3:0]  client;
    bit [7:0]  func;
    bit [63:0] prev_cnt, prev_ts, now, cnt;
    int        k, pick;
    for (int n = 0; n < count; n++) begin
      client = $urandom_range(3) == 0 ? 4'($urandom) : 4'($urandom_range(3));
      func   = $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(7) * 37);
      k        = client * NUM_FUNCS_DEF + func;
      prev_cnt = sb.last_cnt[k];
      prev_ts  = sb.last_ts[k];
      pick     = $urandom_range(99);
      if (pick < 8) begin
        send_item(OP_READ, client, func, rand64(), rand64());
      end else if (pick < 14) begin
        send_item(OP_OBSERVE, client, func, rand64(), rand64());
      end else if (pick < 19) begin
        send_item(OP_OBSERVE, client, func, rand64(), prev_cnt);
      end else if (pick < 24 && prev_cnt != 0) begin
        send_item(OP_OBSERVE, client, func, rand64(), prev_cnt - $urandom_range(1, 99));
      end else if (pick < 29 && prev_ts != 0) begin
        send_item(OP_OBSERVE, client, func, prev_ts - $urandom_range(0, 3),
                  prev_cnt + $urandom_range(1, 50));
      end else begin
        cnt = prev_cnt + (64'($urandom_range(1, 4000)) << $urandom_range(0, 20));
        if (prev_ts == 0) now = 64'($urandom) + 1;
        else now = prev_ts + (64'($urandom_range(1, 65535)) << $urandom_range(0, 30));
        send_item(OP_OBSERVE, client, func, now, cnt);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: first time, init, update, each flag, saturations, extremes
    send_item(OP_READ, 4'd0, 8'd0, 64'd0, 64'd0);
    send_item(OP_OBSERVE, 4'd0, 8'd0, 64'd0, 64'd0);
    send_item(OP_OBSERVE, 4'd0, 8'd1, 64'd1000, 64'd10);
    send_item(OP_OBSERVE, 4'd0, 8'd1, 64'd5001000, 64'd20);
    send_item(OP_OBSERVE, 4'd0, 8'd1, 64'd9001000, 64'd35);
    send_item(OP_OBSERVE, 4'd0, 8'd1, 64'd9501000, 64'd35);
    send_item(OP_OBSERVE, 4'd0, 8'd1, 64'd9601000, 64'd30);
    send_item(OP_OBSERVE, 4'd0, 8'd1, 64'd9001000, 64'd40);
    send_item(OP_OBSERVE, 4'd0, 8'd1, 64'd8001000, 64'd41);
    send_item(OP_READ, 4'd0, 8'd1, '1, '1);
    send_item(OP_OBSERVE, 4'd15, 8'd255, 64'd1, 64'd1);
    send_item(OP_OBSERVE, 4'd15, 8'd255, '1, 64'd2);
    send_item(OP_READ, 4'd15, 8'd255, 64'd0, 64'd0);
    send_item(OP_OBSERVE, 4'd7, 8'd128, 64'd1, 64'd1);
    send_item(OP_OBSERVE, 4'd7, 8'd128, 64'd2, 64'h8000_0000_0000_0001);
    send_item(OP_OBSERVE, 4'd7, 8'd128, 64'd3, '1);
    send_item(OP_OBSERVE, 4'd8, 8'd128, 64'd5, 64'd100);
    send_item(OP_OBSERVE, 4'd8, 8'd128, 64'd123456789, 64'd100000);
    send_item(OP_OBSERVE, 4'd3, 8'd9, 64'd0, 64'd5);
    send_item(OP_OBSERVE, 4'd3, 8'd9, 64'd0, 64'd6);
    send_item(OP_OBSERVE, 4'd3, 8'd9, 64'd700, 64'd7);
    send_item(OP_OBSERVE, 4'd3, 8'd9, 64'd1999999, 64'd8);

    write_discount(17'd0);
    tx_idle_pct = 38;
    rx_idle_pct = 72;
    random_items(360);
    write_discount(DISC_ONE);
    random_items(360);
    write_discount(17'h1FFFF);
    tx_idle_pct = 72;
    rx_idle_pct = 38;
    random_items(360);
    write_discount(17'($urandom_range(1, 65535)));
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_items(360);

    // Drain, then let stray results show up
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
